// File: rtl/rvsc_pkg.sv
package rvsc_pkg;

  typedef enum logic [1:0] {
    CMD_IMEM_WR = 2'd0,
    CMD_DMEM_WR = 2'd1,
    CMD_EXEC    = 2'd2,
    CMD_IGNORE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  load_address;
    logic [31:0] load_data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        reg_write_en;
    logic [3:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        store_en;
    logic [7:0]  store_address;
    logic        store_size;
    logic [31:0] store_value;
  } res_t;

  localparam logic [6:0] OP_ADD   = 7'b0110011;
  localparam logic [6:0] OP_ADDI  = 7'b0010011;
  localparam logic [6:0] OP_LUI   = 7'b0110111;
  localparam logic [6:0] OP_LOAD  = 7'b0000011;
  localparam logic [6:0] OP_STORE = 7'b0100011;
  localparam logic [6:0] OP_JALR  = 7'b1100111;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [6:0] F7_ADD  = 7'd0;

  localparam logic SZ_BYTE = 1'b0;
  localparam logic SZ_WORD = 1'b1;

  function automatic logic [31:0] sext12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

endpackage

// File: rtl/rvsc_ram.sv
// Simple dual-port RAM, registered read data held while re is low.
module rvsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rvsc_rf.sv
// Register file: two synchronous read ports, one write port (read-first).
module rvsc_rf #(
  parameter int NUM_REGS = 16,
  localparam int RW = $clog2(NUM_REGS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [RW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [RW-1:0] raddr1,
  input  logic [RW-1:0] raddr2,
  output logic [31:0]   rdata1,
  output logic [31:0]   rdata2
);

  logic [31:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (we) begin
      regs[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata1 <= regs[raddr1];
      rdata2 <= regs[raddr2];
    end
  end

endmodule

// File: rtl/rv32_subset_core_step_unit.sv
// Small RV32 core stepped one transaction at a time. Each cmd transaction either
// writes an instruction word, writes a data byte, executes the instruction at pc
// (ADD, ADDI, LUI, LW, LBU, SW, SB, JALR; anything else is a no-op, pc += 4), or is
// ignored, and yields exactly one res transaction, in order. All state sits in
// synchronous RAMs: instruction RAM, a 2R1W register file and four byte lanes
// of data RAM (so a wrapped word access reaches all four lanes at once). An execute
// transaction takes the path fetch -> register read -> execute (-> data read for
// loads) -> output register. An execute holds off the next transaction until it
// leaves p1: the fetch of the next one waits until pc of the previous one is
// computed, which is forwarded straight into the instruction RAM address.
// Load/write commands are taken back to back while nothing downstream stalls.
// After reset the block runs a clearing pass over all RAMs and holds cmd_stall
// high until the pass is done.
// IMEM_WORDS and DMEM_BYTES must be powers of two.
module rv32_subset_core_step_unit
  import rvsc_pkg::*;
#(
  parameter int IMEM_WORDS = 256,
  parameter int DMEM_BYTES = 256,
  parameter int NUM_REGS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int IA       = $clog2(IMEM_WORDS);
  localparam int DA       = $clog2(DMEM_BYTES);
  localparam int ROWS     = DMEM_BYTES / 4;
  localparam int RA       = DA - 2;
  localparam int RW       = $clog2(NUM_REGS);
  localparam int CLR_A    = (IMEM_WORDS > ROWS) ? IMEM_WORDS : ROWS;
  localparam int CLR_LEN  = (CLR_A > NUM_REGS) ? CLR_A : NUM_REGS;
  localparam int CW       = $clog2(CLR_LEN);
  localparam logic [31:0] DMASK = 32'(DMEM_BYTES - 1);

  // register index fields wrap at NUM_REGS (at most one subtract, NUM_REGS >= 16)
  function automatic logic [RW-1:0] reg_sel(input logic [4:0] f);
    logic [5:0] w;
    w = {1'b0, f};
    if (w >= 6'(NUM_REGS)) w = w - 6'(NUM_REGS);
    return w[RW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clearing;
  logic [CW-1:0] clr_cnt;
  logic          clr_imem, clr_dmem, clr_rf;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CW'(1);
      if (clr_cnt == CW'(CLR_LEN - 1)) clearing <= 1'b0;
    end
  end

  assign clr_imem = clearing && ({1'b0, clr_cnt} < (CW+1)'(IMEM_WORDS));
  assign clr_dmem = clearing && ({1'b0, clr_cnt} < (CW+1)'(ROWS));
  assign clr_rf   = clearing && ({1'b0, clr_cnt} < (CW+1)'(NUM_REGS));

  // ---------------------------------------------------------------------------
  // Pipeline control
  //   p1: instruction RAM data valid, register file read issued on advance
  //   p2: execute, data RAM write / read issue, pc update
  //   p3: load data back from data RAM
  //   res: output register
  // ---------------------------------------------------------------------------
  logic        cmd_acc;
  logic        out_free;
  logic        p1_v, p1_adv;
  cmd_t        p1_item;
  logic        p2_v, p2_out, p2_to_p3, p2_leave;
  cmd_t        p2_item;
  logic [31:0] p2_ins;
  logic        p3_v, p3_out;
  logic [31:0] pc;

  assign out_free = !res_valid || !res_stall;
  assign cmd_acc  = cmd_valid && !cmd_stall;
  // p1 waits while an older load is still outstanding, so its register read
  // can never miss a write-back except one landing on the same edge (bypassed)
  assign p1_adv   = p1_v && (!p2_v || p2_out) && (!p3_v || p3_out);
  // an execute in p1 has not resolved pc yet: hold off the next transaction
  assign cmd_stall = clearing || (p1_v && (p1_item.command == CMD_EXEC || !p1_adv));

  // ---------------------------------------------------------------------------
  // Instruction RAM: written at accept, read at accept for executes
  // ---------------------------------------------------------------------------
  logic [31:0] fetch_pc;
  logic [31:0] la_ext;
  logic        im_we, im_re;
  logic [IA-1:0] im_waddr;
  logic [31:0] im_wdata, im_rdata;
  logic [31:0] dec_next;
  logic        p2_exec;

  assign p2_exec  = p2_item.command == CMD_EXEC;
  assign fetch_pc = (p2_v && p2_exec) ? dec_next : pc;
  assign la_ext   = 32'(cmd.load_address);
  assign im_we    = clr_imem || (cmd_acc && cmd.command == CMD_IMEM_WR);
  assign im_waddr = clearing ? clr_cnt[IA-1:0] : la_ext[IA-1:0];
  assign im_wdata = clearing ? '0 : cmd.load_data;
  assign im_re    = cmd_acc && cmd.command == CMD_EXEC;

  rvsc_ram #(.WIDTH(32), .DEPTH(IMEM_WORDS)) u_imem (
    .clk   (clk),
    .we    (im_we),
    .waddr (im_waddr),
    .wdata (im_wdata),
    .re    (im_re),
    .raddr (fetch_pc[IA+1:2]),
    .rdata (im_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (cmd_acc) begin
      p1_v <= 1'b1;
    end else if (p1_adv) begin
      p1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) p1_item <= cmd;
  end

  // ---------------------------------------------------------------------------
  // Register file, read as p1 advances; same-edge write captured for bypass
  // ---------------------------------------------------------------------------
  logic [RW-1:0] rs1_sel, rs2_sel;
  logic          rf_we;
  logic [RW-1:0] rf_waddr;
  logic [31:0]   rf_wdata, rf_rdata1, rf_rdata2;
  logic          p2_byp1, p2_byp2, p2_rs1_zero, p2_rs2_zero;
  logic [31:0]   p2_byp_val;

  assign rs1_sel = reg_sel(im_rdata[19:15]);
  assign rs2_sel = reg_sel(im_rdata[24:20]);

  rvsc_rf #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (rf_waddr),
    .wdata  (rf_wdata),
    .re     (p1_adv),
    .raddr1 (rs1_sel),
    .raddr2 (rs2_sel),
    .rdata1 (rf_rdata1),
    .rdata2 (rf_rdata2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (p1_adv) begin
      p2_v <= 1'b1;
    end else if (p2_leave) begin
      p2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_item     <= p1_item;
      p2_ins      <= im_rdata;
      p2_byp1     <= rf_we && (rf_waddr == rs1_sel);
      p2_byp2     <= rf_we && (rf_waddr == rs2_sel);
      p2_byp_val  <= rf_wdata;
      p2_rs1_zero <= rs1_sel == '0;
      p2_rs2_zero <= rs2_sel == '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute (p2)
  // ---------------------------------------------------------------------------
  logic [6:0]    op;
  logic [2:0]    f3;
  logic [6:0]    f7;
  logic [RW-1:0] rd_sel;
  logic [31:0]   rs1v, rs2v, opb, sum, pc_plus4;
  logic          dec_wr, dec_load, dec_store, dec_word;
  logic [31:0]   dec_val;
  logic          p2_wr_ok, p2_load, p2_store;

  assign op       = p2_ins[6:0];
  assign f3       = p2_ins[14:12];
  assign f7       = p2_ins[31:25];
  assign rd_sel   = reg_sel(p2_ins[11:7]);
  assign rs1v     = p2_rs1_zero ? '0 : (p2_byp1 ? p2_byp_val : rf_rdata1);
  assign rs2v     = p2_rs2_zero ? '0 : (p2_byp2 ? p2_byp_val : rf_rdata2);
  assign pc_plus4 = pc + 32'd4;

  always_comb begin
    if (op == OP_ADD) begin
      opb = rs2v;
    end else if (op == OP_STORE) begin
      opb = sext12({p2_ins[31:25], p2_ins[11:7]});
    end else begin
      opb = sext12(p2_ins[31:20]);
    end
  end

  assign sum = rs1v + opb;

  always_comb begin
    dec_wr    = 1'b0;
    dec_val   = '0;
    dec_next  = pc_plus4;
    dec_load  = 1'b0;
    dec_store = 1'b0;
    dec_word  = 1'b0;
    unique case (op)
      OP_ADD: begin
        if (f7 == F7_ADD && f3 == F3_ADD) begin
          dec_wr  = 1'b1;
          dec_val = sum;
        end
      end
      OP_ADDI: begin
        if (f3 == F3_ADD) begin
          dec_wr  = 1'b1;
          dec_val = sum;
        end
      end
      OP_LUI: begin
        dec_wr  = 1'b1;
        dec_val = {p2_ins[31:12], 12'd0};
      end
      OP_LOAD: begin
        dec_load = (f3 == F3_WORD) || (f3 == F3_BU);
        dec_word = f3 == F3_WORD;
      end
      OP_STORE: begin
        dec_store = (f3 == F3_WORD) || (f3 == F3_BYTE);
        dec_word  = f3 == F3_WORD;
      end
      OP_JALR: begin
        if (f3 == F3_ADD) begin
          dec_wr   = 1'b1;
          dec_val  = pc_plus4;
          dec_next = {sum[31:1], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign p2_wr_ok = p2_exec && dec_wr && (rd_sel != '0);
  assign p2_load  = p2_exec && dec_load;
  assign p2_store = p2_exec && dec_store;
  assign p2_out   = p2_v && !p2_load && !p3_v && out_free;
  assign p2_to_p3 = p2_v && p2_load && !p3_v;
  assign p2_leave = p2_out || p2_to_p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (p2_leave && p2_exec) begin
      pc <= dec_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Data RAM: four byte lanes; byte i of an access at a sits in lane (a+i)%4
  // ---------------------------------------------------------------------------
  logic [31:0]   p2_la_ext, dm_addr32, st_addr32;
  logic [RA-1:0] dm_row;
  logic [1:0]    dm_lane0;
  logic          p2_dwr;
  logic [3:0]    dm_we;
  logic [RA-1:0] dm_addr [4];
  logic [7:0]    dm_wdata [4];
  logic [7:0]    dm_rdata [4];
  logic [1:0]    lane_off [4];

  assign p2_dwr    = p2_item.command == CMD_DMEM_WR;
  assign p2_la_ext = 32'(p2_item.load_address);
  assign dm_addr32 = p2_dwr ? p2_la_ext : sum;
  assign dm_row    = dm_addr32[DA-1:2];
  assign dm_lane0  = dm_addr32[1:0];
  assign st_addr32 = sum & DMASK;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_off[l] = 2'(l) - dm_lane0;
      if (clearing) begin
        dm_we[l]    = clr_dmem;
        dm_addr[l]  = clr_cnt[RA-1:0];
        dm_wdata[l] = '0;
      end else begin
        dm_we[l]    = p2_leave && ((p2_dwr && 2'(l) == dm_lane0) ||
                      (p2_store && (dec_word || 2'(l) == dm_lane0)));
        dm_addr[l]  = dm_row + RA'(2'(l) < dm_lane0);
        if (p2_dwr) begin
          dm_wdata[l] = p2_item.load_data[7:0];
        end else if (dec_word) begin
          dm_wdata[l] = rs2v[{lane_off[l], 3'b000} +: 8];
        end else begin
          dm_wdata[l] = rs2v[7:0];
        end
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    rvsc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_dmem (
      .clk   (clk),
      .we    (dm_we[g]),
      .waddr (dm_addr[g]),
      .wdata (dm_wdata[g]),
      .re    (p2_to_p3),
      .raddr (dm_addr[g]),
      .rdata (dm_rdata[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Load completion (p3)
  // ---------------------------------------------------------------------------
  logic [RW-1:0] p3_rd;
  logic          p3_word;
  logic [1:0]    p3_lane0;
  logic [31:0]   p3_val, p3_lw;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (p2_to_p3) begin
      p3_v <= 1'b1;
    end else if (p3_out) begin
      p3_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_to_p3) begin
      p3_rd    <= rd_sel;
      p3_word  <= dec_word;
      p3_lane0 <= dm_lane0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p3_lw[8*i +: 8] = dm_rdata[p3_lane0 + 2'(i)];
    end
  end

  assign p3_val = p3_word ? p3_lw : {24'd0, dm_rdata[p3_lane0]};
  assign p3_out = p3_v && out_free;

  // register file write port: clearing, p2 write-back or load write-back
  assign rf_we    = clr_rf || (p2_out && p2_wr_ok) || (p3_out && p3_rd != '0);
  assign rf_waddr = clearing ? clr_cnt[RW-1:0] : (p3_v ? p3_rd : rd_sel);
  assign rf_wdata = clearing ? '0 : (p3_v ? p3_val : dec_val);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  res_t p2_res, p3_res;

  always_comb begin
    p2_res                 = '0;
    p2_res.pc_after        = p2_exec ? dec_next : pc;
    p2_res.reg_write_en    = p2_wr_ok;
    p2_res.reg_write_index = p2_wr_ok ? 4'(rd_sel) : '0;
    p2_res.reg_write_value = p2_wr_ok ? dec_val : '0;
    if (p2_store) begin
      p2_res.store_en      = 1'b1;
      p2_res.store_address = st_addr32[7:0];
      p2_res.store_size    = dec_word ? SZ_WORD : SZ_BYTE;
      p2_res.store_value   = dec_word ? rs2v : {24'd0, rs2v[7:0]};
    end
  end

  always_comb begin
    p3_res                 = '0;
    p3_res.pc_after        = pc;  // already advanced when the load left p2
    p3_res.reg_write_en    = p3_rd != '0;
    p3_res.reg_write_index = (p3_rd != '0) ? 4'(p3_rd) : '0;
    p3_res.reg_write_value = (p3_rd != '0) ? p3_val : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (p2_out || p3_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_out) begin
      res <= p3_res;
    end else if (p2_out) begin
      res <= p2_res;
    end
  end

endmodule

// File: rtl/rvsc_chk.sv
module rvsc_chk
  import rvsc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // transactions accepted but not yet delivered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(cmd_valid && !cmd_stall) - 3'(res_valid && !res_stall);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> (cmd_stall && !res_valid))
    else $error("cmd not stalled or result shown right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pending != 3'd0))
    else $error("result without an accepted transaction");

  a_depth: assert property (@(posedge clk) disable iff (rst) pending <= 3'd4)
    else $error("more transactions in flight than pipeline stages");

endmodule

bind rv32_subset_core_step_unit rvsc_chk u_rvsc_chk (.*);

// File: test/rv32_subset_core_step_unit_test.sv
`timescale 1ns / 100ps

module rv32_subset_core_step_unit_test;
  import rvsc_pkg::*;

  // Generous ceiling: about 1000 transactions plus the RAM clearing pass after reset,
  // taken many times over.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 950;
  localparam int IDLE_PCT = 36;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [6:0] OPCODES [6] = '{OP_ADD, OP_ADDI, OP_LUI, OP_LOAD, OP_STORE, OP_JALR};

  // Shadow copy of the core: architectural state plus the queue of results that
  // accepted commands are owed, oldest first.
  class core_shadow;
    logic [31:0] regs [16];
    logic [31:0] pc;
    logic [31:0] imem [256];
    logic [7:0]  dmem [256];
    res_t        due_results [$];
    int          errors;
    int          n_exec;
    int          n_reg_wr;
    int          n_load;
    int          n_store;
    int          n_jump;
    int          n_checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (imem[i]) imem[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
    endfunction

    // Runs the instruction at pc and fills in the register and store fields.
    function void execute(ref res_t r);
      logic [31:0] ins, imm_i, imm_s, rs1v, rs2v, addr, wb, nxt;
      logic [6:0]  op, f7;
      logic [2:0]  f3;
      logic [3:0]  rd;
      logic [7:0]  ba;
      logic        do_wb;
      ins   = imem[pc[9:2]];
      op    = ins[6:0];
      rd    = ins[10:7];
      f3    = ins[14:12];
      f7    = ins[31:25];
      rs1v  = regs[ins[18:15]];
      rs2v  = regs[ins[23:20]];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      nxt   = pc + 32'd4;
      wb    = '0;
      do_wb = 1'b0;
      n_exec++;
      case (op)
        OP_ADD: begin
          if (f7 == F7_ADD && f3 == F3_ADD) begin
            wb = rs1v + rs2v;
            do_wb = 1'b1;
          end
        end
        OP_ADDI: begin
          if (f3 == F3_ADD) begin
            wb = rs1v + imm_i;
            do_wb = 1'b1;
          end
        end
        OP_LUI: begin
          wb = {ins[31:12], 12'b0};
          do_wb = 1'b1;
        end
        OP_LOAD: begin
          addr = rs1v + imm_i;
          if (f3 == F3_WORD) begin
            // each byte of the word wraps on its own
            for (int k = 0; k < 4; k++) begin
              ba = addr[7:0] + 8'(k);
              wb[8*k +: 8] = dmem[ba];
            end
            do_wb = 1'b1;
            n_load++;
          end else if (f3 == F3_BU) begin
            wb = {24'b0, dmem[addr[7:0]]};
            do_wb = 1'b1;
            n_load++;
          end
        end
        OP_STORE: begin
          addr = rs1v + imm_s;
          if (f3 == F3_WORD) begin
            for (int k = 0; k < 4; k++) begin
              ba = addr[7:0] + 8'(k);
              dmem[ba] = rs2v[8*k +: 8];
            end
            r.store_en = 1'b1;
            r.store_size = SZ_WORD;
            r.store_address = addr[7:0];
            r.store_value = rs2v;
            n_store++;
          end else if (f3 == F3_BYTE) begin
            dmem[addr[7:0]] = rs2v[7:0];
            r.store_en = 1'b1;
            r.store_size = SZ_BYTE;
            r.store_address = addr[7:0];
            r.store_value = {24'b0, rs2v[7:0]};
            n_store++;
          end
        end
        OP_JALR: begin
          if (f3 == F3_ADD) begin
            nxt = (rs1v + imm_i) & ~32'd1;
            wb = pc + 32'd4;
            do_wb = 1'b1;
            n_jump++;
          end
        end
        default: ;
      endcase
      // x0 writes are dropped and leave no trace in the result
      if (do_wb && rd != 4'd0) begin
        regs[rd] = wb;
        r.reg_write_en = 1'b1;
        r.reg_write_index = rd;
        r.reg_write_value = wb;
        n_reg_wr++;
      end
      pc = nxt;
    endfunction

    function void note_command(cmd_t c);
      res_t r;
      r = '0;
      case (c.command)
        CMD_IMEM_WR: imem[c.load_address] = c.load_data;
        CMD_DMEM_WR: dmem[c.load_address] = c.load_data[7:0];
        CMD_EXEC:    execute(r);
        default: ;
      endcase
      r.pc_after = pc;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t act);
      res_t exp_r;
      if (due_results.size() == 0) begin
        $display("%0t: result with no transaction outstanding: %h", $time, act);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      n_checked++;
      compare_field("pc_after", exp_r.pc_after, act.pc_after);
      compare_field("reg_write_en", 32'(exp_r.reg_write_en), 32'(act.reg_write_en));
      compare_field("reg_write_index", 32'(exp_r.reg_write_index),
                    32'(act.reg_write_index));
      compare_field("reg_write_value", exp_r.reg_write_value, act.reg_write_value);
      compare_field("store_en", 32'(exp_r.store_en), 32'(act.store_en));
      compare_field("store_address", 32'(exp_r.store_address), 32'(act.store_address));
      compare_field("store_size", 32'(exp_r.store_size), 32'(act.store_size));
      compare_field("store_value", exp_r.store_value, act.store_value);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  core_shadow shadow = new();
  int idle_pct = IDLE_PCT;
  int stall_pct = IDLE_PCT;
  int sent_items = 0;
  int cycle_count = 0;

  rv32_subset_core_step_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("** rv32_subset_core_step_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: random back-pressure, applied at the falling edge.
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Results are taken at the rising edge, when handshake signals are settled.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      shadow.check_result(res);
    end
  end

  function automatic logic [31:0] enc_r(input logic [4:0] rd, rs1, rs2);
    return {F7_ADD, rs2, rs1, F3_ADD, rd, OP_ADD};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                        input logic [4:0] rd, rs1, input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1, rs2,
                                        input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_u(input logic [4:0] rd, input logic [19:0] imm);
    return {imm, rd, OP_LUI};
  endfunction

  // Mostly legal instructions with random registers (bit 4 of each register
  // field included) and immediates; one case in ten has random funct bits.
  function automatic logic [31:0] rand_insn();
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    rd  = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    imm = 12'($urandom);
    case ($urandom_range(9))
      0:       return enc_r(rd, rs1, rs2);
      1, 2:    return enc_i(OP_ADDI, F3_ADD, rd, rs1, imm);
      3:       return enc_u(rd, 20'($urandom));
      4:       return enc_i(OP_LOAD, F3_WORD, rd, rs1, imm);
      5:       return enc_i(OP_LOAD, F3_BU, rd, rs1, imm);
      6:       return enc_s(F3_WORD, rs1, rs2, imm);
      7:       return enc_s(F3_BYTE, rs1, rs2, imm);
      8:       return enc_i(OP_JALR, F3_ADD, rd, rs1, imm);
      default: return enc_i(OPCODES[$urandom_range(5)], 3'($urandom), rd, rs1, imm);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // cmd_valid still high, so back-to-back transactions need no extra toggle.
  task automatic send_command(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      cmd.load_address <= 8'($urandom);
      cmd.load_data <= $urandom;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    shadow.note_command(c);
    if (c.command != CMD_IGNORE) sent_items++;
    @(negedge clk);
  endtask

  task automatic write_insn(input logic [7:0] idx, input logic [31:0] word);
    send_command('{CMD_IMEM_WR, idx, word});
  endtask

  task automatic write_byte(input logic [7:0] addr, input logic [31:0] data);
    send_command('{CMD_DMEM_WR, addr, data});
  endtask

  // Load fields are don't-care on execute, so they carry noise.
  task automatic step_core();
    send_command('{CMD_EXEC, 8'($urandom), $urandom});
  endtask

  task automatic wait_results_drained();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (shadow.due_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] prog [10];
    int          pick;
    bit          paused_mid;
    paused_mid = 1'b0;

    // hand-built program at words 1..10, run after the reset-state no-op
    prog[0] = enc_u(5'd1, 20'hFFFFF);                          // x1 = ffff_f000
    prog[1] = enc_i(OP_ADDI, F3_ADD, 5'd2, 5'd0, 12'hFFF);     // x2 = -1
    prog[2] = enc_r(5'd3, 5'd1, 5'd2);                         // add
    prog[3] = enc_s(F3_WORD, 5'd16, 5'd2, 12'hFFF);            // sw wraps past byte 255
    prog[4] = enc_i(OP_LOAD, F3_WORD, 5'd4, 5'd0, 12'd253);    // lw straddles the wrap
    prog[5] = enc_i(OP_LOAD, F3_BU, 5'd5, 5'd0, 12'h7FF);      // lbu, largest positive imm
    prog[6] = enc_s(F3_BYTE, 5'd1, 5'd3, 12'h800);             // sb, most negative imm
    prog[7] = enc_i(OP_ADDI, F3_ADD, 5'd0, 5'd1, 12'd5);       // write to x0 dropped
    prog[8] = enc_r(5'd3, 5'd1, 5'd2) | 32'h4000_0000;         // bad funct7: no-op
    prog[9] = enc_i(OP_JALR, F3_ADD, 5'd22, 5'd1, 12'd7);      // odd target, bit 1 set

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part: reset no-op, ignored command, memory extremes, program.
    step_core();
    send_command('{CMD_IGNORE, 8'hFF, 32'hFFFF_FFFF});
    write_byte(8'hFF, 32'hFFFF_FFFF);
    write_byte(8'h00, 32'hFFFF_FFA5);
    for (int i = 0; i < 10; i++) write_insn(8'(i + 1), prog[i]);
    for (int i = 0; i < 11; i++) step_core();
    wait_results_drained();

    // Random part. Most traffic plants an instruction at pc and runs it; the
    // rest is raw memory traffic, blind steps, junk words and ignored commands.
    while (sent_items < RANDOM_ITEMS) begin
      // quiet stretch in the middle: no idling on either side
      idle_pct = (sent_items >= 350 && sent_items < 550) ? 0 : IDLE_PCT;
      stall_pct = idle_pct;
      if (!paused_mid && sent_items >= 700) begin
        wait_results_drained();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        write_insn(shadow.pc[9:2], rand_insn());
        step_core();
      end else if (pick < 65) begin
        step_core();
      end else if (pick < 75) begin
        write_byte(8'($urandom), $urandom);
      end else if (pick < 83) begin
        write_insn(8'($urandom), rand_insn());
      end else if (pick < 90) begin
        write_insn(shadow.pc[9:2], $urandom);
        step_core();
      end else if (pick < 95) begin
        send_command('{CMD_IGNORE, 8'($urandom), $urandom});
      end else begin
        write_insn(8'($urandom), $urandom);
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (shadow.due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, shadow.due_results.size());
      shadow.errors++;
    end
    $display("Checked %0d results over %0d commands; %0d steps executed.",
             shadow.n_checked, sent_items, shadow.n_exec);
    $display("Steps covered %0d register writes, %0d loads, %0d stores, %0d jumps.",
             shadow.n_reg_wr, shadow.n_load, shadow.n_store, shadow.n_jump);
    if (shadow.errors == 0) begin
      $display("** rv32_subset_core_step_unit: PASSED **");
    end else begin
      $display("** rv32_subset_core_step_unit: FAILED **");
    end
    $finish;
  end

endmodule
